[rtl/ais_pkg.sv]
// Package for the ascending integer sorter: widths, payload types, cell control, FSM states.
`default_nettype none

package ais_pkg;

    // Element width is fixed by the payload format
    localparam int WIDTH = 32;
    // Default number of insertion cells (set capacity)
    localparam int DEPTH_DEF = 64;

    typedef logic signed [WIDTH-1:0] t_value;

    // Input request: one element of the set
    typedef struct packed {
        t_value value;
        logic   last;
    } t_in_req;

    // Output request: one sorted element
    typedef struct packed {
        t_value value_res;
        logic   last_res;
        logic   overflowed;
    } t_out_res;

    // Control shared by every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

endpackage : ais_pkg

`default_nettype wire

[rtl/ais_cell.sv]
// One insertion cell: holds a sorted element, inserts or shifts with its neighbors.
`default_nettype none

module ais_cell
    import ais_pkg::*;
(
    input  wire        i_clk,
    input  t_cell_ctl  i_ctl,
    input  t_value     i_new,
    input  t_value     i_left,
    input  t_value     i_right,
    input  wire        i_left_gt,
    input  wire        i_occupied,
    output t_value     o_value,
    output logic       o_gt
);

    t_value r_value;
    t_value n_value;

    // Empty cells, or cells strictly greater than the new element, move right.
    // Equal held values stay ahead of the newcomer, which keeps the order stable.
    always_comb begin
        o_gt = !i_occupied || (r_value > i_new);
    end

    always_comb begin
        n_value = r_value;
        if (i_ctl.shift) begin
            n_value = i_right;
        end else if (i_ctl.insert) begin
            if (i_left_gt) begin
                n_value = i_left;
            end else if (o_gt) begin
                n_value = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule : ais_cell

`default_nettype wire

[rtl/ascending_integer_sorter.sv]
// Top level of the ascending integer sorter: insertion cell chain, count and output stage.
// Input: one element per cycle while filling, inserted in place as taken, or dropped if full.
// After the element flagged last, the state register turns to drain and the output register then
// gives the results one per cycle while the receiver is ready, smallest first.
// No input is taken while a set drains; a set gives one result per stored element.
// Reset (i_rst_n low, synchronous) empties the chain and clears count, overflow and valid.
`default_nettype none

module ascending_integer_sorter
    import ais_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_ready,
    input  t_in_req   i_in_req,
    output logic      o_out_valid,
    input  wire       i_out_ready,
    output t_out_res  o_out_res
);

    localparam int CW = $clog2(DEPTH + 1);

    t_state         r_state;
    t_state         n_state;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic           r_ov;
    logic           n_ov;
    logic           r_out_valid;
    logic           n_out_valid;
    t_out_res       r_out;
    t_out_res       n_out;

    logic           w_in_acc;
    logic           w_full;
    logic           w_load;
    logic           w_final;
    t_cell_ctl      w_ctl;

    // Value chain: index 0 is the new element, i+1 is cell i, DEPTH+1 feeds the end
    t_value         w_val [DEPTH+2];
    logic           w_gt  [DEPTH+1];

    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_final  = (r_count == CW'(1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL: begin
                if (w_in_acc && i_in_req.last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_load && w_final) begin
                    n_state = ST_FILL;
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_load     = 1'b0;
        unique case (r_state)
            ST_FILL: begin
                o_in_ready = 1'b1;
            end
            ST_DRAIN: begin
                w_load = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Cell control
    always_comb begin
        w_ctl.insert = w_in_acc && !w_full;
        w_ctl.shift  = w_load;
    end

    // Element count and overflow flag
    always_comb begin
        n_count = r_count;
        n_ov    = r_ov;
        if (w_ctl.insert) begin
            n_count = r_count + CW'(1);
        end else if (w_load) begin
            n_count = r_count - CW'(1);
        end
        if (w_in_acc && w_full) begin
            n_ov = 1'b1;
        end else if (w_load && w_final) begin
            n_ov = 1'b0;
        end
    end

    // Output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_load) begin
            n_out_valid      = 1'b1;
            n_out.value_res  = w_val[1];
            n_out.last_res   = w_final;
            n_out.overflowed = w_final && r_ov;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_count     <= '0;
            r_ov        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ov        <= n_ov;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Cell chain
    assign w_val[0]       = i_in_req.value;
    assign w_val[DEPTH+1] = '0;
    assign w_gt[0]        = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        ais_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_new      (i_in_req.value),
            .i_left     (w_val[i]),
            .i_right    (w_val[i+2]),
            .i_left_gt  (w_gt[i]),
            .i_occupied (r_count > CW'(i)),
            .o_value    (w_val[i+1]),
            .o_gt       (w_gt[i+1])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule : ascending_integer_sorter

`default_nettype wire

[rtl/ais_checker.sv]
// Port-level checker for the ascending integer sorter, bound to the top level.
`default_nettype none

module ais_checker
    import ais_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       o_in_ready,
    input t_in_req   i_in_req,
    input wire       o_out_valid,
    input wire       i_out_ready,
    input t_out_res  o_out_res
);

    // Reset leaves no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_res)))
        else $error("stalled result changed");

    // Overflow is reported on the final result only
    a_ov_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_res.overflowed) |-> o_out_res.last_res)
        else $error("overflow flag on a non-final result");

    // No new element is taken while a set is still draining
    a_no_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_res.last_res) |-> !o_in_ready)
        else $error("input ready during drain");

    // Taking the last element of a set closes the input for the drain
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_req.last) |=> !o_in_ready)
        else $error("input still ready after last element");

endmodule : ais_checker

bind ascending_integer_sorter ais_checker u_ais_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_res   (o_out_res)
);

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the ascending integer sorter: directed, capacity and random sets.
`timescale 1ns / 1ps

module tb;
    import ais_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 70;
    localparam int IDLE_PCT     = 38;
    localparam int TAIL_CYCLES  = 8;

    localparam t_value VAL_MIN = {1'b1, {(WIDTH-1){1'b0}}};
    localparam t_value VAL_MAX = {1'b0, {(WIDTH-1){1'b1}}};

    // Value styles for random sets
    localparam int STYLE_WIDE     = 0;
    localparam int STYLE_NARROW   = 1;
    localparam int STYLE_EXTREMES = 2;
    localparam int STYLE_MIXED    = 3;

    logic     i_clk;
    logic     i_rst_n;
    logic     in_valid;
    t_in_req  in_req;
    logic     out_ready;
    logic     o_in_ready;
    logic     o_out_valid;
    t_out_res o_out_res;

    // Sorter state as predicted
    t_value   set_store[$];
    bit       set_dropped;
    t_out_res sorted_q[$];

    bit       no_idle;
    int       errors;
    int       cycles;
    int       items_sent;
    int       sets_closed;
    int       overflow_sets;
    int       results_checked;
    t_out_res want;

    ascending_integer_sorter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_res   (o_out_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Store one element if there is room; on the last one, sort stably and queue the expected results
    task automatic collect_element(input t_in_req req);
        t_value   tmp;
        t_out_res res;
        if (set_store.size() < DEPTH) begin
            set_store.push_back(req.value);
        end else begin
            set_dropped = 1'b1;
        end
        if (req.last) begin
            // swap only on strictly greater, so equal values keep arrival order
            for (int p = 0; p < set_store.size(); p++) begin
                for (int j = 0; j + 1 + p < set_store.size(); j++) begin
                    if (set_store[j] > set_store[j+1]) begin
                        tmp            = set_store[j];
                        set_store[j]   = set_store[j+1];
                        set_store[j+1] = tmp;
                    end
                end
            end
            foreach (set_store[k]) begin
                res.value_res  = set_store[k];
                res.last_res   = (k == set_store.size() - 1);
                res.overflowed = res.last_res && set_dropped;
                sorted_q.push_back(res);
            end
            sets_closed++;
            if (set_dropped) begin
                overflow_sets++;
            end
            set_store.delete();
            set_dropped = 1'b0;
        end
    endtask

    // Offer one request, with random idle cycles ahead of it; returns at the next falling edge
    task automatic send_element(input t_value v, input logic lst);
        t_in_req req;
        req.value = v;
        req.last  = lst;
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge i_clk); while (!o_in_ready);
        collect_element(req);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Sender holds off until every queued result has been taken
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (sorted_q.size() != 0);
    endtask

    function automatic t_value rand_value(input int style);
        int pick;
        if (style == STYLE_MIXED) begin
            style = $urandom_range(STYLE_EXTREMES);
        end
        case (style)
            STYLE_WIDE: begin
                return t_value'($urandom);
            end
            STYLE_NARROW: begin
                pick = $urandom_range(6);
                return t_value'(pick - 3);
            end
            default: begin
                pick = $urandom_range(3);
                case (pick)
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    task automatic send_set(input int size, input int style);
        for (int i = 0; i < size; i++) begin
            send_element(rand_value(style), i == size - 1);
        end
    endtask

    // Sets of one element, at both ends of the range and at zero
    task automatic test_single_element();
        send_element(VAL_MIN, 1'b1);
        send_element(VAL_MAX, 1'b1);
        send_element('0, 1'b1);
        wait_results_drained();
    endtask

    // Extremes with duplicates in one set
    task automatic test_extremes();
        send_element(VAL_MAX, 1'b0);
        send_element(VAL_MIN, 1'b0);
        send_element('0, 1'b0);
        send_element('1, 1'b0);
        send_element(t_value'(1), 1'b0);
        send_element(VAL_MIN, 1'b0);
        send_element(VAL_MAX, 1'b0);
        send_element(VAL_MIN + t_value'(1), 1'b0);
        send_element(VAL_MAX - t_value'(1), 1'b1);
        wait_results_drained();
    endtask

    // Reverse-ordered and already ordered sets
    task automatic test_presorted_orders();
        for (int i = 0; i < 5; i++) begin
            send_element(t_value'(100 - 50 * i), i == 4);
        end
        for (int i = 0; i < 4; i++) begin
            send_element(t_value'(-7 + 3 * i), i == 3);
        end
        wait_results_drained();
    endtask

    // Long stretch with neither side idling
    task automatic test_back_to_back();
        no_idle = 1'b1;
        for (int s = 0; s < 4; s++) begin
            send_set($urandom_range(4, 10), STYLE_MIXED);
        end
        wait_results_drained();
        no_idle = 1'b0;
    endtask

    // Exactly full store, then a set whose tail is dropped, though its last flag still closes the set
    task automatic test_capacity();
        send_set(DEPTH, STYLE_WIDE);
        wait_results_drained();
        send_set(DEPTH + 2, STYLE_MIXED);
        wait_results_drained();
    endtask

    task automatic test_random_sets();
        int stop_at;
        int roll;
        int size;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 15) begin
                size = 1;
            end else if (roll < 85) begin
                size = $urandom_range(2, 12);
            end else if (roll < 97) begin
                size = $urandom_range(13, 40);
            end else begin
                size = $urandom_range(DEPTH - 1, DEPTH + 3);
            end
            send_set(size, $urandom_range(STYLE_MIXED));
            if ($urandom_range(9) == 0) begin
                wait_results_drained();
            end
        end
        wait_results_drained();
    endtask

    // Receiver stalls at random, except during the back-to-back stretch
    always @(negedge i_clk) begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare each taken result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (sorted_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %p", $time, o_out_res);
            end else begin
                want = sorted_q.pop_front();
                results_checked++;
                if (o_out_res.value_res !== want.value_res) begin
                    errors++;
                    $display("%0t: value_res mismatch, expected %0d, got %0d",
                             $time, want.value_res, o_out_res.value_res);
                end
                if (o_out_res.last_res !== want.last_res) begin
                    errors++;
                    $display("%0t: last_res mismatch, expected %b, got %b",
                             $time, want.last_res, o_out_res.last_res);
                end
                if (o_out_res.overflowed !== want.overflowed) begin
                    errors++;
                    $display("%0t: overflowed mismatch, expected %b, got %b",
                             $time, want.overflowed, o_out_res.overflowed);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_req    = '0;
        out_ready = 1'b0;
        no_idle   = 1'b0;
        set_dropped     = 1'b0;
        errors          = 0;
        cycles          = 0;
        items_sent      = 0;
        sets_closed     = 0;
        overflow_sets   = 0;
        results_checked = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_single_element();
        test_extremes();
        test_presorted_orders();
        test_back_to_back();
        test_capacity();
        test_random_sets();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (sorted_q.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never came", $time, sorted_q.size());
        end
        $display("Sent %0d elements in %0d sets (%0d with dropped elements);", items_sent,
                 sets_closed, overflow_sets);
        $display("checked %0d sorted results, %0d errors", results_checked, errors);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

[ascending_integer_sorter.f]
rtl/ais_pkg.sv
rtl/ais_cell.sv
rtl/ascending_integer_sorter.sv
rtl/ais_checker.sv
test/tb.sv
